### sv/rlbp_pkg.sv
// ----------------------------------------------------------------------------
// rlbp_pkg
// shared types and constants of the run led blink pattern generator
// ----------------------------------------------------------------------------
package rlbp_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ON     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_PER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ON     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PER    = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SLOW_ON    = 16'd500;
    localparam logic [CFG_W-1:0] RST_SLOW_PER   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_SINGLE_ON  = 16'd1;
    localparam logic [CFG_W-1:0] RST_SINGLE_PER = 16'd1000;
    localparam logic [CFG_W-1:0] RST_FAST_ON    = 16'd100;
    localparam logic [CFG_W-1:0] RST_FAST_PER   = 16'd200;

    // indicator modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLICK  = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] slow_on_ticks;
        logic [CFG_W-1:0] slow_period;
        logic [CFG_W-1:0] single_on_ticks;
        logic [CFG_W-1:0] single_period;
        logic [CFG_W-1:0] fast_on_ticks;
        logic [CFG_W-1:0] fast_period;
    } cfg_t;

    // outcome of one counter step: lit, dark, or neither (restart, hold level)
    typedef struct packed {
        logic lit;
        logic dark;
    } step_t;

endpackage

### sv/run_led_blink_pattern.sv
// ----------------------------------------------------------------------------
// run_led_blink_pattern
// run indicator led pattern generator, one level per millisecond tick
// ----------------------------------------------------------------------------
// Each request carries the indicator mode for one tick and yields one level.
// A tick is taken every clock cycle unless the output stalls; the request
// passes the input register, then the level register (also the output
// register), with the counter increment and compare in between. Threshold
// and period registers must be written only while no tick is in flight; the block does not enforce this.
module run_led_blink_pattern #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [2:0] led_mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [0] led_lit
    input  logic                           cfg_wr_en,
    input  logic [rlbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlbp_pkg::CFG_W-1:0]     cfg_data
);
    import rlbp_pkg::*;

    cfg_t              cfg;
    step_t             slow_step;
    step_t             single_step;
    step_t             fast_step;
    step_t             sel_step;

    logic              in_valid_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              out_valid_reg;
    logic              lit_level_reg;
    logic              lit_level_next;
    logic              out_free;
    logic              advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    rlbp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlbp_pattern_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_slow (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance && (mode_reg == MODE_BLINK)),
        .on_ticks (cfg.slow_on_ticks),
        .period   (cfg.slow_period),
        .step     (slow_step)
    );

    rlbp_pattern_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_single (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance && (mode_reg == MODE_SINGLE)),
        .on_ticks (cfg.single_on_ticks),
        .period   (cfg.single_period),
        .step     (single_step)
    );

    rlbp_pattern_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_fast (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance && (mode_reg == MODE_FLICK)),
        .on_ticks (cfg.fast_on_ticks),
        .period   (cfg.fast_period),
        .step     (fast_step)
    );

    always_comb
    begin
        sel_step       = '0;
        lit_level_next = lit_level_reg;
        unique case (mode_reg)
            MODE_OFF:    lit_level_next = 1'b0;
            MODE_ON:     lit_level_next = 1'b1;
            MODE_BLINK:  sel_step = slow_step;
            MODE_SINGLE: sel_step = single_step;
            MODE_FLICK:  sel_step = fast_step;
            default:     lit_level_next = lit_level_reg;
        endcase
        if (sel_step.lit)
        begin
            lit_level_next = 1'b1;
        end
        else if (sel_step.dark)
        begin
            lit_level_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mode_reg      <= MODE_OFF;
            out_valid_reg <= 1'b0;
            lit_level_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    mode_reg <= s_axis_tdata[MODE_W-1:0];
                end
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                lit_level_reg <= lit_level_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, lit_level_reg};

endmodule

### sv/rlbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// rlbp_cfg_regs
// threshold and period registers, written through the plain write port
// ----------------------------------------------------------------------------
module rlbp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rlbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlbp_pkg::CFG_W-1:0]     cfg_data,
    output rlbp_pkg::cfg_t                 cfg
);
    import rlbp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SLOW_ON:    cfg_next.slow_on_ticks   = cfg_data;
                CFG_SLOW_PER:   cfg_next.slow_period     = cfg_data;
                CFG_SINGLE_ON:  cfg_next.single_on_ticks = cfg_data;
                CFG_SINGLE_PER: cfg_next.single_period   = cfg_data;
                CFG_FAST_ON:    cfg_next.fast_on_ticks   = cfg_data;
                CFG_FAST_PER:   cfg_next.fast_period     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_on_ticks   <= RST_SLOW_ON;
            cfg_reg.slow_period     <= RST_SLOW_PER;
            cfg_reg.single_on_ticks <= RST_SINGLE_ON;
            cfg_reg.single_period   <= RST_SINGLE_PER;
            cfg_reg.fast_on_ticks   <= RST_FAST_ON;
            cfg_reg.fast_period     <= RST_FAST_PER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/rlbp_pattern_counter.sv
// ----------------------------------------------------------------------------
// rlbp_pattern_counter
// one pattern counter: increments, compares against on threshold and period
// ----------------------------------------------------------------------------
module rlbp_pattern_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic [rlbp_pkg::CFG_W-1:0] on_ticks,
    input  logic [rlbp_pkg::CFG_W-1:0] period,
    output rlbp_pkg::step_t            step
);
    import rlbp_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       cnt_cmp;

    always_comb
    begin
        cnt_inc   = cnt_reg + COUNT_WIDTH'(1);
        cnt_cmp   = CMP_W'(cnt_inc);
        step.lit  = (cnt_cmp <= CMP_W'(on_ticks));
        step.dark = !step.lit && (cnt_cmp < CMP_W'(period));
        cnt_next  = cnt_reg;
        if (step_en)
        begin
            cnt_next = (step.lit || step.dark) ? cnt_inc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/rlbp_checker.sv
// ----------------------------------------------------------------------------
// rlbp_checker
// port level checks of the run led blink pattern generator
// ----------------------------------------------------------------------------
module rlbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // result request stays up while stalled
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    // stalled result keeps its level
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input side only backs up when the output side is full and stalled
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // level only moves into a free output slot
    a_level_change: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tdata != $past(m_axis_tdata) |->
            $past(!m_axis_tvalid || m_axis_tready) && m_axis_tvalid)
        else $error("level changed without a new result");

    // only bit zero of the result carries the level
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

endmodule

bind run_led_blink_pattern rlbp_checker u_rlbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
